// ----- rtl/wstb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstb_pkg
// Shared types and constants of the wavelet sample to byte converter.
// ----------------------------------------------------------------------------
package wstb_pkg;

   localparam int SAMPLE_W      = 32;
   localparam int PIXEL_W       = 8;
   localparam int DEPTH_W       = 6;
   localparam int SUM_W         = SAMPLE_W + 1;
   localparam int SHIFT_W       = 5;
   localparam int UPSHIFT_W     = 3;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam int FIX_FRACTION_BITS = 13;
   localparam int FIX_DS            = FIX_FRACTION_BITS - 8;
   localparam int FIX_ROUND         = 1 << (FIX_DS - 1);

   localparam int PIXEL_BITS   = 8;
   localparam int LEVEL_OFFSET = 128;
   localparam int PIXEL_MAX    = 255;
   localparam int DEPTH_MAX    = 32;
   localparam int DEPTH_RESET  = 8;

   typedef enum logic [1:0] {
      FMT_FLOAT = 2'd0,
      FMT_INT32 = 2'd1,
      FMT_FIX16 = 2'd2,
      FMT_INT16 = 2'd3
   } fmt_type;

   typedef enum logic {
      CSR_FORMAT = 1'b0,
      CSR_DEPTH  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      fmt_type              fmt;
      logic [DEPTH_W-1:0]   depth;
   } cfg_type;

   // stage one result: rounded sum and shift controls
   typedef struct packed {
      logic [SUM_W-1:0]     sum;
      logic [SHIFT_W-1:0]   ds;
      logic                 up;
      logic [UPSHIFT_W-1:0] us;
   } prep_type;

   // stage two result: down-shifted value
   typedef struct packed {
      logic [SUM_W-1:0]     val;
      logic                 up;
      logic [UPSHIFT_W-1:0] us;
   } shift_type;

endpackage

// ----- rtl/wstb_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstb_csr
// Register file for sample format and bit depth, APB-style access.
// ----------------------------------------------------------------------------
module wstb_csr import wstb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   fmt_type            format_ff, format_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   csr_idx_type        idx;
   logic               wr_en;

   assign idx        = csr_idx_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      format_in = format_ff;
      depth_in  = depth_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_FORMAT: format_in = fmt_type'(csr_pwdata[1:0]);
            CSR_DEPTH:  depth_in  = csr_pwdata[DEPTH_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_FLOAT;
         depth_ff  <= DEPTH_W'(DEPTH_RESET);
      end else begin
         format_ff <= format_in;
         depth_ff  <= depth_in;
      end
   end

   always_comb begin
      unique case (idx)
         CSR_FORMAT: csr_prdata = {{(CSR_DATA_W-2){1'b0}}, format_ff};
         CSR_DEPTH:  csr_prdata = {{(CSR_DATA_W-DEPTH_W){1'b0}}, depth_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.fmt   = format_ff;
   assign cfg.depth = depth_ff;

endmodule

// ----- rtl/wstb_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstb_prep
// Stage one: format decode, depth limits and rounding offset add.
// ----------------------------------------------------------------------------
module wstb_prep import wstb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   output logic                out_valid,
   input  logic                out_ready,
   output prep_type            out_data
);

   logic                 valid_ff, valid_in;
   prep_type             data_ff, data_in;
   logic [DEPTH_W-1:0]   depth_c;
   logic                 deep;
   logic [SUM_W-1:0]     s32_x, s16_x, operand, offset;
   logic [15:0]          fix_wrap;
   logic [SHIFT_W-1:0]   ds;
   logic [SHIFT_W-1:0]   ds_deep;
   logic                 up;
   logic [UPSHIFT_W-1:0] us;

   always_comb begin
      if (cfg.depth == '0) begin
         depth_c = DEPTH_W'(1);
      end else if (cfg.depth > DEPTH_W'(DEPTH_MAX)) begin
         depth_c = DEPTH_W'(DEPTH_MAX);
      end else begin
         depth_c = cfg.depth;
      end
   end

   assign deep     = depth_c >= DEPTH_W'(PIXEL_BITS);
   assign ds_deep  = SHIFT_W'(depth_c - DEPTH_W'(PIXEL_BITS));
   assign s32_x    = {in_sample[SAMPLE_W-1], in_sample};
   assign s16_x    = {{(SUM_W-16){in_sample[15]}}, in_sample[15:0]};
   assign fix_wrap = in_sample[15:0] + 16'(FIX_ROUND);

   always_comb begin
      operand = s32_x;
      offset  = '0;
      ds      = '0;
      up      = 1'b0;
      us      = UPSHIFT_W'(DEPTH_W'(PIXEL_BITS) - depth_c);
      case (cfg.fmt)
         FMT_FLOAT: begin
            offset = SUM_W'(LEVEL_OFFSET);
            ds     = SHIFT_W'(PIXEL_BITS);
         end
         FMT_INT32: begin
            if (deep) begin
               ds = ds_deep;
            end
            if (ds != '0) begin
               offset = SUM_W'(1) << (ds - SHIFT_W'(1));
            end
         end
         FMT_FIX16: begin
            if (deep) begin
               operand = {{(SUM_W-16){fix_wrap[15]}}, fix_wrap};
               ds      = SHIFT_W'(FIX_DS);
            end else begin
               operand = s16_x;
               ds      = SHIFT_W'(DEPTH_W'(FIX_FRACTION_BITS) - depth_c);
               offset  = SUM_W'(1) << (ds - SHIFT_W'(1));
               up      = 1'b1;
            end
         end
         default: begin
            operand = s16_x;
            if (deep) begin
               ds = ds_deep;
               if (ds == '0 || ds > SHIFT_W'(16)) begin
                  offset = '0;
               end else if (ds == SHIFT_W'(16)) begin
                  // rounding offset wraps to the most negative 16-bit value
                  offset = {{(SUM_W-15){1'b1}}, 15'd0};
               end else begin
                  offset = SUM_W'(1) << (ds - SHIFT_W'(1));
               end
            end else begin
               up = 1'b1;
            end
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in     = in_valid;
         data_in.sum  = operand + offset;
         data_in.ds   = ds;
         data_in.up   = up;
         data_in.us   = us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_prep_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("stage one lost or changed a stalled item");

endmodule

// ----- rtl/wstb_shift.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstb_shift
// Stage two: arithmetic right shift by the down-shift amount.
// ----------------------------------------------------------------------------
module wstb_shift import wstb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  prep_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output shift_type out_data
);

   logic      valid_ff, valid_in;
   shift_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in    = in_valid;
         data_in.val = SUM_W'($signed(in_data.sum) >>> in_data.ds);
         data_in.up  = in_data.up;
         data_in.us  = in_data.us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_shift_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("stage two lost or changed a stalled item");

endmodule

// ----- rtl/wstb_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstb_pack
// Stage three: up-shift, level shift, clamp and output register.
// ----------------------------------------------------------------------------
module wstb_pack import wstb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  shift_type          in_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PIXEL_W-1:0] rsp_pixel
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic [PIXEL_W-1:0] pixel;
   logic [SUM_W:0]     lvl;
   logic [15:0]        up_val, up_lvl;
   logic [PIXEL_W:0]   high_x;

   assign lvl    = {in_data.val[SUM_W-1], in_data.val} + (SUM_W+1)'(LEVEL_OFFSET);
   assign up_val = in_data.val[15:0] << in_data.us;
   assign up_lvl = up_val + 16'(LEVEL_OFFSET);
   assign high_x = (PIXEL_W+1)'(PIXEL_MAX + 1) - ((PIXEL_W+1)'(1) << in_data.us);

   always_comb begin
      if (in_data.up) begin
         if (up_lvl[15]) begin
            pixel = '0;
         end else if (up_lvl > 16'(PIXEL_MAX)) begin
            pixel = high_x[PIXEL_W-1:0];
         end else begin
            pixel = up_lvl[PIXEL_W-1:0];
         end
      end else begin
         if (lvl[SUM_W]) begin
            pixel = '0;
         end else if (lvl > (SUM_W+1)'(PIXEL_MAX)) begin
            pixel = PIXEL_W'(PIXEL_MAX);
         end else begin
            pixel = lvl[PIXEL_W-1:0];
         end
      end
   end

   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (in_ready) begin
         rsp_valid_in = in_valid;
         rsp_pixel_in = pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

   // up-shifted pixels and their clamp value are always even
   a_pack_even: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && in_data.up |=> !rsp_pixel_ff[0])
      else $error("up-shifted pixel has its low bit set");

endmodule

// ----- rtl/wavelet_sample_to_byte.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavelet_sample_to_byte
// Converts decoded wavelet samples to level-shifted, clamped 8-bit pixels.
// ----------------------------------------------------------------------------
// One sample in, one pixel out. The datapath is three register stages
// (rounding add, arithmetic down-shift, up-shift/level-shift/clamp into the
// output register), which a sample passes through in that order; a new sample can be
// taken every cycle unless the output stalls, and stages advance
// independently, so bubbles close up under output stalls. Format and bit
// depth are written through the csr port and must only change while the
// pipeline is empty.
module wavelet_sample_to_byte import wstb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_W-1:0]    rsp_pixel,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type   cfg;
   logic      s1_valid, s1_ready;
   prep_type  s1_data;
   logic      s2_valid, s2_ready;
   shift_type s2_data;

   wstb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wstb_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_sample),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   wstb_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   wstb_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pixel (rsp_pixel)
   );

   a_top_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid)
      else $error("accepted sample did not reach stage one");

   a_top_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid && !s2_valid && !rsp_valid |-> req_ready)
      else $error("empty pipeline refuses a transfer");

endmodule
